### rtl/gnce_pkg.sv
// Shared constants, types and helper functions of the grid neighbour cell enumerator.
package gnce_pkg;

   // Grid geometry and span cap.
   localparam int GRID_X   = 32;
   localparam int GRID_Y   = 32;
   localparam int GRID_Z   = 32;
   localparam int MAX_SPAN = 4;

   localparam int GRID_XY_MAX = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GRID_WIDEST = (GRID_XY_MAX > GRID_Z) ? GRID_XY_MAX : GRID_Z;

   // Widths of coordinates and per-axis cell counters.
   localparam int COORD_W = (GRID_WIDEST > 1) ? $clog2(GRID_WIDEST) : 1;
   localparam int SPAN_W  = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

   // Payload and arithmetic widths.
   localparam int POS_W     = 32;
   localparam int H_W       = 31;
   localparam int CFG_W     = 32;
   localparam int IDX_W     = 15;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_W     = 32;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int FRAC_W    = 16;
   localparam int RAD_W     = H_W + CFG_W - FRAC_W + 1;
   localparam int Q_W       = RAD_W + 2;
   localparam int D_W       = Q_W + 1;
   localparam int HI_W      = Q_W - MUL_W;
   localparam int SUM_W     = HI_W + MUL_W + 1;
   localparam int CALC_W    = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_ORIGIN_Z      = 3'd2,
      CSR_INV_CELL_SIZE = 3'd3,
      CSR_RADIUS_SCALE  = 3'd4,
      CSR_RADIUS_BIAS   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAD_MUL,
      ST_RAD_ADD,
      ST_CORNER_Q,
      ST_CORNER_D,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CLAMP,
      ST_SPAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] origin_x;
      logic signed [CFG_W-1:0] origin_y;
      logic signed [CFG_W-1:0] origin_z;
      logic [CFG_W-1:0]        inv_cell_size;
      logic [CFG_W-1:0]        radius_scale;
      logic [CFG_W-1:0]        radius_bias;
   } cfg_type;

   typedef struct packed {
      logic     load;
      logic     rad_mul;
      logic     rad_add;
      logic     corner_q;
      logic     corner_d;
      logic     mul_lo;
      logic     mul_hi;
      logic     clamp;
      logic     span;
      logic     emit;
      axis_type axis;
      logic     upper;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_cell;
   } dp_status_type;

   // Highest cell coordinate on an axis.
   function automatic logic [COORD_W-1:0] grid_limit(input axis_type axis);
      logic [COORD_W-1:0] lim;
      case (axis)
         AXIS_X:  lim = COORD_W'(GRID_X - 1);
         AXIS_Y:  lim = COORD_W'(GRID_Y - 1);
         AXIS_Z:  lim = COORD_W'(GRID_Z - 1);
         default: lim = COORD_W'(GRID_X - 1);
      endcase
      return lim;
   endfunction

endpackage

### rtl/gnce_csr.sv
// Configuration register file of the grid neighbour cell enumerator.
module gnce_csr
   import gnce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:      cfg_in.origin_x      = csr_wdata;
            CSR_ORIGIN_Y:      cfg_in.origin_y      = csr_wdata;
            CSR_ORIGIN_Z:      cfg_in.origin_z      = csr_wdata;
            CSR_INV_CELL_SIZE: cfg_in.inv_cell_size = csr_wdata;
            CSR_RADIUS_SCALE:  cfg_in.radius_scale  = csr_wdata;
            CSR_RADIUS_BIAS:   cfg_in.radius_bias   = csr_wdata;
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x      <= '0;
         cfg_ff.origin_y      <= '0;
         cfg_ff.origin_z      <= '0;
         cfg_ff.inv_cell_size <= CFG_W'(65536);
         cfg_ff.radius_scale  <= CFG_W'(65536);
         cfg_ff.radius_bias   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/gnce_ctrl.sv
// Sequencing state machine of the grid neighbour cell enumerator.
module gnce_ctrl
   import gnce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   axis_type  axis_ff, axis_in;
   logic      upper_ff, upper_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
         upper_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         upper_ff <= upper_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      upper_in  = upper_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      cmd.upper = upper_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RAD_MUL;
            end
         end
         ST_RAD_MUL: begin
            cmd.rad_mul = 1'b1;
            state_in    = ST_RAD_ADD;
         end
         ST_RAD_ADD: begin
            cmd.rad_add = 1'b1;
            axis_in     = AXIS_X;
            upper_in    = 1'b0;
            state_in    = ST_CORNER_Q;
         end
         ST_CORNER_Q: begin
            cmd.corner_q = 1'b1;
            state_in     = ST_CORNER_D;
         end
         ST_CORNER_D: begin
            cmd.corner_d = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            if (!upper_ff) begin
               upper_in = 1'b1;
               state_in = ST_CORNER_Q;
            end else begin
               upper_in = 1'b0;
               case (axis_ff)
                  AXIS_X: begin
                     axis_in  = AXIS_Y;
                     state_in = ST_CORNER_Q;
                  end
                  AXIS_Y: begin
                     axis_in  = AXIS_Z;
                     state_in = ST_CORNER_Q;
                  end
                  default: begin
                     axis_in  = AXIS_X;
                     state_in = ST_SPAN;
                  end
               endcase
            end
         end
         ST_SPAN: begin
            cmd.span = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_cell) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/gnce_datapath.sv
// Arithmetic, corner coordinate store, cell counters and output register.
module gnce_datapath
   import gnce_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [H_W-1:0]          req_smoothing_len,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_cell_index,
   output logic                    rsp_last,
   output logic                    rsp_truncated
);

   logic [POS_W-1:0]   pos_ff [3];
   logic [H_W-1:0]     h_ff;
   logic [RAD_W-1:0]   r_ff, r_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [PROD_W-1:0]  mprod_ff, mprod_in;
   logic [MUL_W-1:0]   frac_ff;
   logic [COORD_W-1:0] lo_ff [3];
   logic [COORD_W-1:0] hi_ff [3];
   logic [COORD_W-1:0] coord_in;
   logic [SPAN_W-1:0]  last_ff [3], last_in [3];
   logic [SPAN_W-1:0]  cnt_ff [3], cnt_in [3];
   logic               trunc_ff, trunc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic               rsp_last_ff, rsp_trunc_ff;

   logic [POS_W-1:0]   p_sel;
   logic [CFG_W-1:0]   org_sel;
   logic [Q_W-1:0]     p_ext, r_ext;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [SUM_W-1:0]   sum;
   logic [COORD_W-1:0] limit;
   logic               d_pos;
   logic [CALC_W-1:0]  idx_calc;
   logic               last_cell;

   // Per-axis operand selection.
   always_comb begin
      case (cmd.axis)
         AXIS_X: begin
            p_sel   = pos_ff[0];
            org_sel = cfg.origin_x;
         end
         AXIS_Y: begin
            p_sel   = pos_ff[1];
            org_sel = cfg.origin_y;
         end
         AXIS_Z: begin
            p_sel   = pos_ff[2];
            org_sel = cfg.origin_z;
         end
         default: begin
            p_sel   = pos_ff[0];
            org_sel = cfg.origin_x;
         end
      endcase
   end

   assign p_ext = {{(Q_W - POS_W){p_sel[POS_W-1]}}, p_sel};
   assign r_ext = {{(Q_W - RAD_W){1'b0}}, r_ff};
   assign q_in  = cmd.upper ? (p_ext + r_ext) : (p_ext - r_ext);
   assign d_in  = {q_ff[Q_W-1], q_ff} - {{(D_W - CFG_W){org_sel[CFG_W-1]}}, org_sel};
   assign r_in  = RAD_W'(mprod_ff[H_W+CFG_W-1:FRAC_W]) + RAD_W'(cfg.radius_bias);

   // Shared multiplier: radius product, then the low and high halves of each
   // corner distance against the reciprocal cell size.
   always_comb begin
      if (cmd.rad_mul) begin
         mul_a = {1'b0, h_ff};
         mul_b = cfg.radius_scale;
      end else if (cmd.mul_hi) begin
         mul_a = {{(MUL_W - HI_W){1'b0}}, d_ff[Q_W-1:MUL_W]};
         mul_b = cfg.inv_cell_size;
      end else begin
         mul_a = d_ff[MUL_W-1:0];
         mul_b = cfg.inv_cell_size;
      end
   end

   assign mprod_in = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

   // Floor of the full product, clamped to the grid.
   assign sum   = SUM_W'(mprod_ff[HI_W+MUL_W-1:0]) + SUM_W'(frac_ff);
   assign limit = grid_limit(cmd.axis);
   assign d_pos = !d_ff[D_W-1] && (d_ff != '0);

   always_comb begin
      if (!d_pos) begin
         coord_in = '0;
      end else if (sum > SUM_W'(limit)) begin
         coord_in = limit;
      end else begin
         coord_in = sum[COORD_W-1:0];
      end
   end

   // Span per axis, capped at the maximum span.
   always_comb begin
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] diff;
      trunc_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         top  = (hi_ff[a] < lo_ff[a]) ? lo_ff[a] : hi_ff[a];
         diff = top - lo_ff[a];
         if (diff > COORD_W'(MAX_SPAN - 1)) begin
            last_in[a] = SPAN_W'(MAX_SPAN - 1);
            trunc_in   = 1'b1;
         end else begin
            last_in[a] = diff[SPAN_W-1:0];
         end
      end
   end

   assign last_cell = (cnt_ff[0] == last_ff[0]) && (cnt_ff[1] == last_ff[1])
                      && (cnt_ff[2] == last_ff[2]);

   // Odometer over the box, z innermost.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.span) begin
         cnt_in[0] = '0;
         cnt_in[1] = '0;
         cnt_in[2] = '0;
      end else if (cmd.emit) begin
         if (cnt_ff[2] != last_ff[2]) begin
            cnt_in[2] = cnt_ff[2] + 1'b1;
         end else begin
            cnt_in[2] = '0;
            if (cnt_ff[1] != last_ff[1]) begin
               cnt_in[1] = cnt_ff[1] + 1'b1;
            end else begin
               cnt_in[1] = '0;
               cnt_in[0] = cnt_ff[0] + 1'b1;
            end
         end
      end
   end

   assign idx_calc = CALC_W'(lo_ff[0]) + CALC_W'(cnt_ff[0])
                   + (CALC_W'(lo_ff[1]) + CALC_W'(cnt_ff[1])) * CALC_W'(GRID_X)
                   + (CALC_W'(lo_ff[2]) + CALC_W'(cnt_ff[2])) * CALC_W'(GRID_X * GRID_Y);

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.last_cell = last_cell;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         h_ff      <= req_smoothing_len;
      end
      if (cmd.rad_mul || cmd.mul_lo || cmd.mul_hi) begin
         mprod_ff <= mprod_in;
      end
      if (cmd.mul_hi) begin
         frac_ff <= mprod_ff[PROD_W-1:MUL_W];
      end
      if (cmd.rad_add) begin
         r_ff <= r_in;
      end
      if (cmd.corner_q) begin
         q_ff <= q_in;
      end
      if (cmd.corner_d) begin
         d_ff <= d_in;
      end
      if (cmd.clamp) begin
         if (cmd.upper) begin
            hi_ff[cmd.axis] <= coord_in;
         end else begin
            lo_ff[cmd.axis] <= coord_in;
         end
      end
      if (cmd.span) begin
         last_ff  <= last_in;
         trunc_ff <= trunc_in;
      end
      cnt_ff <= cnt_in;
      if (cmd.emit) begin
         rsp_idx_ff   <= idx_calc[IDX_W-1:0];
         rsp_last_ff  <= last_cell;
         rsp_trunc_ff <= trunc_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_idx_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_truncated  = rsp_trunc_ff;

endmodule

### rtl/grid_neighbor_cell_enumerator_core.sv
// Top level of the grid neighbour cell enumerator: registers, controller and datapath.
// Each item is taken in turn: its radius, its six box corners and its spans are computed
// first, then its N cells are enumerated, N being its cell count (1 to 64);
// one shared 32 x 32 multiplier works through the radius and the six box corners in turn.
// Cell indices then leave at one per cycle unless the result side stalls.
// Reset (synchronous, active high) empties the output register, idles the controller and
// returns every configuration register to its documented reset value.
module grid_neighbor_cell_enumerator_core
   import gnce_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Particle input channel.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [H_W-1:0]          req_smoothing_len,
   // Cell index result channel.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_cell_index,
   output logic                    rsp_last,
   output logic                    rsp_truncated,
   // Configuration write channel.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   // The configuration registers are always ready; writes are expected only while
   // the block is idle, so the datapath reads them directly without shadowing.
   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   gnce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The controller takes a new item only in its idle state. It then steps the
   // datapath through the radius product, the six corner conversions (low and high
   // corner for x, y and z), the span calculation and the enumeration of the box.
   // It returns to idle as soon as the final index has moved into the output
   // register, so the next item can be accepted while that index still waits.
   gnce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the item, the shared multiplier, the corner coordinates,
   // the cell counters and the output register that decouples the result side.
   gnce_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_smoothing_len (req_smoothing_len),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_last          (rsp_last),
      .rsp_truncated     (rsp_truncated)
   );

endmodule
